>>> rtl/assert_macros.svh
// Assertion macros used by the top level of the task picker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Checks that the condition never holds out of reset.
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

>>> rtl/tsp_pkg.sv
// Types and constants shared by the task picker modules.
`default_nettype none

package tsp_pkg;

   localparam int unsigned PRIO_W = 8;
   localparam logic [PRIO_W-1:0] INIT_SLICE = 8'd10;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [PRIO_W-1:0] ticks;
   } task_word_type;

   typedef struct packed {
      logic              clear;
      logic              strobe;
      logic [PRIO_W-1:0] value;
      task_word_type     word;
   } scan_ctl_type;

endpackage

`default_nettype wire

>>> rtl/tsp_ram.sv
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module tsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/tsp_scan.sv
// Shared compare unit that tracks the largest value seen during a slot scan.
`default_nettype none

module tsp_scan #(
   parameter int IDX_W = 6
) (
   input  logic                        clock,
   input  tsp_pkg::scan_ctl_type       ctl,
   input  logic [IDX_W-1:0]            cand_idx,
   output logic [tsp_pkg::PRIO_W-1:0]  best_value,
   output logic [IDX_W-1:0]            best_idx,
   output tsp_pkg::task_word_type      best_word
);

   logic [tsp_pkg::PRIO_W-1:0] best_ff;
   logic [tsp_pkg::PRIO_W-1:0] best_in;
   logic [IDX_W-1:0]           idx_ff;
   logic [IDX_W-1:0]           idx_in;
   tsp_pkg::task_word_type     word_ff;
   tsp_pkg::task_word_type     word_in;
   logic                       take;

   // Strictly greater keeps the lowest-numbered slot on a tie.
   assign take = ctl.strobe && (ctl.value > best_ff);

   always_comb begin
      best_in = best_ff;
      idx_in  = idx_ff;
      word_in = word_ff;
      if (ctl.clear) begin
         best_in = '0;
         idx_in  = '0;
         word_in = '0;
      end else if (take) begin
         best_in = ctl.value;
         idx_in  = cand_idx;
         word_in = ctl.word;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      idx_ff  <= idx_in;
      word_ff <= word_in;
   end

   assign best_value = best_ff;
   assign best_idx   = idx_ff;
   assign best_word  = word_ff;

endmodule

`default_nettype wire

>>> rtl/time_slice_task_picker.sv
// Top level of the time-slice task picker: slot table, scan sequencer and result register.
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  tuser mode; tdata priority, slot, privilege
//   rsp_     out        rsp_tvalid/rsp_tready  tdata pick, ticks, flags
//
// A tick word with a nonzero privilege level scans the slot memory once, one slot per
// cycle; when every valid slot is out of ticks a refill scan follows. A tick word at
// privilege level zero is taken without a response. After reset slot zero holds ten
// ticks at priority ten. A word is taken while an earlier result still waits; the
// sequencer holds its finished result until the output register is free.
`default_nettype none
`include "assert_macros.svh"

module time_slice_task_picker #(
   parameter int TASK_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,  // mode
   input  logic [23:0] req_tdata,  // privilege_level, slot, task_priority
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // picked_slot, ticks_left, refilled, none_ready, create_ok
);

   localparam int SW = $clog2(TASK_SLOTS);
   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam logic [SW-1:0] LAST_IDX = SW'(TASK_SLOTS - 1);
   localparam logic [CW-1:0] SLOT_CNT = CW'(TASK_SLOTS);
   localparam logic [7:0]    SLOT_LIM = 8'(TASK_SLOTS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN1  = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SCAN2  = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [SW-1:0]         rd_idx_ff, rd_idx_in;
   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [TASK_SLOTS-1:0] written_ff, written_in;
   logic                  create_ff, create_in;
   logic                  ok_ff, ok_in;
   logic                  refill_ff, refill_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]           rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   req_mode;
   logic [1:0]             req_priv;
   logic [6:0]             req_slot;
   logic [7:0]             req_prio;
   logic                   slot_ok;
   logic                   scanning;
   logic                   issue;
   logic                   out_free;
   logic                   fin_load;
   logic                   none_ready;
   logic                   cur_valid;
   tsp_pkg::task_word_type ram_rd;
   tsp_pkg::task_word_type cur_word;
   tsp_pkg::task_word_type wr_word;
   logic                   wr_en;
   logic [SW-1:0]          wr_addr;
   tsp_pkg::scan_ctl_type  scan_ctl;
   logic [7:0]             best_value;
   logic [SW-1:0]          best_idx;
   tsp_pkg::task_word_type best_word;
   logic [6:0]             pick_wide;
   logic [7:0]             dec_ticks;

   assign req_mode = req_tuser[0];
   assign req_priv = req_tdata[1:0];
   assign req_slot = req_tdata[8:2];
   assign req_prio = req_tdata[16:9];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_ok    = ({1'b0, req_slot} < SLOT_LIM);
   assign scanning   = (state_ff == ST_SCAN1) || (state_ff == ST_SCAN2);
   assign issue      = scanning && (cnt_ff != SLOT_CNT);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign fin_load   = (state_ff == ST_FIN) && out_free;
   assign none_ready = (best_value == '0);

   // A slot never written since reset reads as its reset contents.
   always_comb begin
      if (written_ff[rd_idx_ff]) begin
         cur_word = ram_rd;
      end else if (rd_idx_ff == '0) begin
         cur_word = '{prio: tsp_pkg::INIT_SLICE, ticks: tsp_pkg::INIT_SLICE};
      end else begin
         cur_word = '0;
      end
   end
   assign cur_valid = valid_ff[rd_idx_ff];

   always_comb begin
      scan_ctl.clear  = (accept && !req_mode) ||
                        ((state_ff == ST_DECIDE) && none_ready);
      scan_ctl.strobe = scanning && rd_vld_ff && cur_valid;
      if (state_ff == ST_SCAN1) begin
         scan_ctl.value = cur_word.ticks;
         scan_ctl.word  = cur_word;
      end else begin
         scan_ctl.value = cur_word.prio;
         scan_ctl.word  = '{prio: cur_word.prio, ticks: cur_word.prio};
      end
   end

   assign dec_ticks = best_word.ticks - 8'd1;
   assign pick_wide = 7'(best_idx);

   // The three writers of the slot memory belong to different states.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_word = '0;
      if (accept && req_mode && slot_ok) begin
         wr_en   = 1'b1;
         wr_addr = req_slot[SW-1:0];
         wr_word = '{prio: req_prio, ticks: req_prio};
      end else if ((state_ff == ST_SCAN2) && rd_vld_ff && cur_valid) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
         wr_word = '{prio: cur_word.prio, ticks: cur_word.prio};
      end else if (fin_load && !create_ff && !none_ready) begin
         wr_en   = 1'b1;
         wr_addr = best_idx;
         wr_word = '{prio: best_word.prio, ticks: dec_ticks};
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
         if (accept) begin
            valid_in[wr_addr] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      create_in = create_ff;
      ok_in     = ok_ff;
      refill_in = refill_ff;
      rd_vld_in = issue;
      rd_idx_in = issue ? cnt_ff[SW-1:0] : rd_idx_ff;
      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               create_in = req_mode;
               ok_in     = req_mode && slot_ok;
               refill_in = 1'b0;
               cnt_in    = '0;
               if (req_mode) begin
                  state_in = ST_FIN;
               end else if (req_priv != 2'd0) begin
                  state_in = ST_SCAN1;
               end
            end
         end
         ST_SCAN1: begin
            if (rd_vld_ff && (rd_idx_ff == LAST_IDX)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (none_ready) begin
               state_in  = ST_SCAN2;
               refill_in = 1'b1;
               cnt_in    = '0;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SCAN2: begin
            if (rd_vld_ff && (rd_idx_ff == LAST_IDX)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (fin_load) begin
         rsp_tvalid_in = 1'b1;
         if (create_ff) begin
            rsp_data_in = {7'd0, ok_ff, 16'd0};
         end else if (none_ready) begin
            rsp_data_in = {7'd0, 1'b0, 1'b1, refill_ff, 8'd0, 6'd0};
         end else begin
            rsp_data_in = {7'd0, 1'b0, 1'b0, refill_ff, dec_ticks, pick_wide[5:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         valid_ff      <= TASK_SLOTS'(1);
         written_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         valid_ff      <= valid_in;
         written_ff    <= written_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      create_ff   <= create_in;
      ok_ff       <= ok_in;
      refill_ff   <= refill_in;
      rsp_data_ff <= rsp_data_in;
   end

   tsp_ram #(
      .WIDTH (2 * tsp_pkg::PRIO_W),
      .DEPTH (TASK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (issue),
      .rd_addr (cnt_ff[SW-1:0]),
      .rd_data (ram_rd)
   );

   tsp_scan #(
      .IDX_W (SW)
   ) u_scan (
      .clock      (clock),
      .ctl        (scan_ctl),
      .cand_idx   (rd_idx_ff),
      .best_value (best_value),
      .best_idx   (best_idx),
      .best_word  (best_word)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMPLIES(a_none_means_refill, clock, reset, rsp_tvalid && rsp_tdata[15], rsp_tdata[14])
   `ASSERT_IMPLIES(a_create_fields_zero, clock, reset, rsp_tvalid && rsp_tdata[16], rsp_tdata[15:0] == 16'd0)
   `ASSERT_IMPLIES(a_refill_scan_flag, clock, reset, state_ff == ST_SCAN2, refill_ff)
   `ASSERT_NEVER(a_read_outside_scan, clock, reset, rd_vld_ff && !scanning)

endmodule

`default_nettype wire
